// File: rtl/fsmf_pkg.sv
// Package for the first substring match finder.
// Holds the payload types, configuration register indexes and fixed widths.
// No dependencies.
`default_nettype none

package fsmf_pkg;

    // Fixed widths of the configuration registers and result fields
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int LEN_W      = 5;
    localparam int REG_BYTES  = 16;
    localparam int POS_OUT_W  = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN = 2'd2;

    typedef logic [REG_BYTES-1:0][7:0] t_pattern;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic                 found;
        logic [POS_OUT_W-1:0] match_position;
    } t_out_item;

endpackage

`default_nettype wire

// File: rtl/fsmf_if.sv
// Valid/ready channel interfaces for the input bytes and the results.
// Depends on fsmf_pkg for the payload types.
`default_nettype none

interface fsmf_in_if import fsmf_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface fsmf_out_if import fsmf_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/fsmf_window_cmp.sv
// Parallel compare of the byte window against the pattern for every length.
// Depends on fsmf_pkg for the pattern type and widths.
`default_nettype none

module fsmf_window_cmp import fsmf_pkg::*; #(
    parameter int CMP_MAX = 16
) (
    input  wire logic [CMP_MAX-1:0][7:0] i_window,
    input  wire t_pattern                i_pattern,
    input  wire logic [LEN_W-1:0]        i_len,
    output logic                         o_match
);

    logic [CMP_MAX-1:0][CMP_MAX-1:0] eq;
    logic [CMP_MAX-1:0]              len_hit;

    // Pattern byte k lines up with window entry L-1-k for a length L
    for (genvar gl = 1; gl <= CMP_MAX; gl++) begin : g_len
        for (genvar gk = 0; gk < CMP_MAX; gk++) begin : g_byte
            if (gk < gl) begin : g_used
                assign eq[gl-1][gk] = (i_window[gl-1-gk] == i_pattern[gk]);
            end else begin : g_unused
                assign eq[gl-1][gk] = 1'b1;
            end
        end
        assign len_hit[gl-1] = (i_len == LEN_W'(gl)) && (&eq[gl-1]);
    end

    // Zero length and lengths past the window select nothing
    assign o_match = |len_hit;

endmodule

`default_nettype wire

// File: rtl/first_substring_match_finder.sv
// Top level of the first substring match finder.
// Depends on fsmf_pkg, the channel interfaces in fsmf_if and fsmf_window_cmp.
`default_nettype none

// The block takes a buffer one byte per transaction on i_in_ch, the final
// byte flagged by last_byte, and returns one transaction on o_res_ch for each
// buffer: found, and the zero-based start of the first occurrence of the
// configured pattern (0 when not found). The pattern (up to 16 bytes, byte 0
// in the low bits of r_pat_lo) and its length are written through
// the plain write port at any time the block is idle; a length of zero, or
// one above PATTERN_MAX or 16, never matches. Throughput is one byte per
// clock: each byte sits in an input register while the window compare and
// the counter update run, and a buffer result is loaded into the result
// register from its final byte in the input register. A pending result
// waits in the result register while the next buffer keeps streaming;
// only a second final byte stalls until the first result has been taken.
// The byte counter is POSITION_BITS wide and saturates; bytes past that
// point are shifted in but never start a match. All search state clears
// after each final byte; the pattern registers keep their values.
module first_substring_match_finder import fsmf_pkg::*; #(
    parameter int PATTERN_MAX   = 16,
    parameter int POSITION_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    fsmf_in_if.sink                    i_in_ch,
    fsmf_out_if.source                 o_res_ch
);

    // Only lengths the registers can hold are ever compared
    localparam int CMP_MAX = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;

    // Configuration registers
    logic [CFG_DATA_W-1:0] r_pat_lo;
    logic [CFG_DATA_W-1:0] r_pat_hi;
    logic [LEN_W-1:0]      r_pat_len;

    // Input register
    logic     r_in_valid;
    t_in_item r_in_item;

    // Search state
    logic [CMP_MAX-1:0][7:0]   r_window, n_window;
    logic [POSITION_BITS-1:0]  r_count, n_count;
    logic                      r_seen, n_seen;
    logic [POSITION_BITS-1:0]  r_start, n_start;

    // Result register
    logic      r_out_valid;
    t_out_item r_out_item;

    logic                     advance;
    logic                     in_accept;
    logic                     indexed;
    logic [POSITION_BITS-1:0] count_inc;
    logic [POSITION_BITS-1:0] len_ext;
    logic                     win_match;
    logic [POS_OUT_W-1:0]     start_out;
    t_pattern                 pattern;

    // Configuration writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PAT_LO:  r_pat_lo  <= i_cfg_data;
                CFG_PAT_HI:  r_pat_hi  <= i_cfg_data;
                CFG_PAT_LEN: r_pat_len <= i_cfg_data[LEN_W-1:0];
                default:     ;
            endcase
        end
    end

    assign pattern = {r_pat_hi, r_pat_lo};

    // Advance the registered byte unless it is a final byte and the previous
    // result is still waiting to be taken
    assign advance   = r_in_valid && (!r_in_item.last_byte || !r_out_valid || o_res_ch.ready);
    assign i_in_ch.ready = !r_in_valid || advance;
    assign in_accept = i_in_ch.valid && i_in_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_in_ch.payload;
        end
    end

    // Shift the new byte in at entry 0
    always_comb begin
        n_window[0] = r_in_item.data_byte;
        for (int i = 1; i < CMP_MAX; i++) begin
            n_window[i] = r_window[i-1];
        end
    end

    fsmf_window_cmp #(
        .CMP_MAX (CMP_MAX)
    ) u_cmp (
        .i_window  (n_window),
        .i_pattern (pattern),
        .i_len     (r_pat_len),
        .o_match   (win_match)
    );

    // A saturated counter stops indexing, so no match can start there
    assign indexed   = (r_count != {POSITION_BITS{1'b1}});
    assign count_inc = r_count + POSITION_BITS'(1);
    assign len_ext   = POSITION_BITS'(r_pat_len);

    always_comb begin
        n_count = r_count;
        n_seen  = r_seen;
        n_start = r_start;
        if (indexed) begin
            n_count = count_inc;
            // Record only the first match; the window must hold len real bytes
            if (!r_seen && win_match && (count_inc >= len_ext)) begin
                n_seen  = 1'b1;
                n_start = count_inc - len_ext;
            end
        end
    end

    // Update or hold the search state per byte; clear after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_count  <= '0;
            r_seen   <= 1'b0;
            r_start  <= '0;
        end else if (advance) begin
            if (r_in_item.last_byte) begin
                r_window <= '0;
                r_count  <= '0;
                r_seen   <= 1'b0;
                r_start  <= '0;
            end else begin
                r_window <= n_window;
                r_count  <= n_count;
                r_seen   <= n_seen;
                r_start  <= n_start;
            end
        end
    end

    // Report the start position in 32 bits: truncate or zero-extend
    if (POSITION_BITS >= POS_OUT_W) begin : g_pos_trunc
        assign start_out = n_start[POS_OUT_W-1:0];
    end else begin : g_pos_ext
        assign start_out = {{(POS_OUT_W-POSITION_BITS){1'b0}}, n_start};
    end

    // Result register: load on a final byte, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_item.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_res_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_item.last_byte) begin
            r_out_item.found          <= n_seen;
            r_out_item.match_position <= n_seen ? start_out : '0;
        end
    end

    assign o_res_ch.valid   = r_out_valid;
    assign o_res_ch.payload = r_out_item;

endmodule

`default_nettype wire
